[hw/rtl/fraction_sum_reducer_assert.svh]
// Assertion macros for the fraction sum reducer
`ifndef FRACTION_SUM_REDUCER_ASSERT_SVH
`define FRACTION_SUM_REDUCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define FSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fraction_sum_reducer: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define FSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fraction_sum_reducer: next-cycle check failed");

`endif

[hw/rtl/fsr_pkg.sv]
// Shared types and constants for the fraction sum reducer
package fsr_pkg;

  localparam int IN_W    = 16;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 31;
  localparam int PROD_W  = 50;
  localparam int MAG_W   = 48;
  localparam int SHIFT_W = 6;
  localparam int CNT_W   = 6;

  localparam logic [MAG_W-1:0] NUM_POS_MAX = 48'd2147483647;
  localparam logic [MAG_W-1:0] NUM_NEG_MAX = 48'd2147483648;
  localparam logic [MAG_W-1:0] DEN_MAX     = 48'd2147483647;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL_AD,
    S_MUL_BN,
    S_MUL_BD,
    S_ABS,
    S_GCD,
    S_DIV,
    S_UPDATE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_first;
    logic mul_ad;
    logic mul_bn;
    logic mul_bd;
    logic abs_load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic acc_update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_group;
    logic last;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/fsr_if.sv]
// Request channels for fractions in and reduced sums out
interface fsr_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [fsr_pkg::IN_W-1:0] numerator;
  logic        [fsr_pkg::IN_W-1:0] denominator;
  logic                            last;

  modport source (output valid, output numerator, output denominator, output last,
                  input ready);
  modport sink (input valid, input numerator, input denominator, input last,
                output ready);
endinterface

interface fsr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fsr_pkg::NUM_W-1:0] sum_numerator;
  logic        [fsr_pkg::DEN_W-1:0] sum_denominator;
  logic                             overflow;

  modport source (output valid, output sum_numerator, output sum_denominator,
                  output overflow, input ready);
  modport sink (input valid, input sum_numerator, input sum_denominator,
                input overflow, output ready);
endinterface

[hw/rtl/fraction_sum_reducer.sv]
// Top level of the fraction sum reducer
// Sums a group of fractions exactly, one fraction per request, and returns the sum at the
// request marked last, reduced to lowest terms if the group holds more than one fraction.
// The first fraction of a group is loaded as given. Every later fraction runs three passes
// through one shared 33x17 multiplier, a binary gcd that removes one bit or one factor of
// two per cycle, and a pair of restoring dividers that divide numerator and denominator by
// the gcd in lockstep over all 48 quotient bits. A new fraction is taken as soon as the
// previous one is folded in and, after the last of a group, its sum has moved into the
// output register, where a finished sum may wait. A reduced sum beyond 32 signed bits, or
// a denominator beyond 31 bits, saturates and raises overflow for the rest of the group.
`include "fraction_sum_reducer_assert.svh"

module fraction_sum_reducer (
  input  logic      clk,
  input  logic      rst,
  fsr_in_if.sink    fraction,
  fsr_out_if.source result
);

  fsr_pkg::cmd_t    cmd;
  fsr_pkg::status_t status;
  logic             ready;

  fsr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .fraction_valid (fraction.valid),
    .fraction_ready (ready),
    .status         (status),
    .cmd            (cmd)
  );

  fsr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .numerator   (fraction.numerator),
    .denominator (fraction.denominator),
    .last        (fraction.last),
    .result      (result)
  );

  assign fraction.ready = ready;

  `FSR_ASSERT_NEXT(a_accept_then_busy, fraction.valid && fraction.ready, !fraction.ready)
  `FSR_ASSERT_NEXT(a_emit_loads_result, cmd.emit, result.valid)
  `FSR_ASSERT_SAME(a_emit_needs_room, cmd.emit, status.out_free)
  `FSR_ASSERT_SAME(a_update_after_div, cmd.acc_update, status.div_done)

endmodule

[hw/rtl/fsr_ctrl.sv]
// Controller state machine that sequences one fraction through the datapath
module fsr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             fraction_valid,
  output logic             fraction_ready,
  input  fsr_pkg::status_t status,
  output fsr_pkg::cmd_t    cmd
);

  fsr_pkg::state_t state;
  fsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    fraction_ready = 1'b0;
    unique case (state)
      fsr_pkg::S_IDLE: begin
        fraction_ready = 1'b1;
        if (fraction_valid) begin
          cmd.capture = 1'b1;
          state_next  = fsr_pkg::S_LOAD;
        end
      end
      fsr_pkg::S_LOAD: begin
        if (!status.in_group) begin
          cmd.load_first = 1'b1;
          state_next     = status.last ? fsr_pkg::S_EMIT : fsr_pkg::S_IDLE;
        end else begin
          state_next = fsr_pkg::S_MUL_AD;
        end
      end
      fsr_pkg::S_MUL_AD: begin
        cmd.mul_ad = 1'b1;
        state_next = fsr_pkg::S_MUL_BN;
      end
      fsr_pkg::S_MUL_BN: begin
        cmd.mul_bn = 1'b1;
        state_next = fsr_pkg::S_MUL_BD;
      end
      fsr_pkg::S_MUL_BD: begin
        cmd.mul_bd = 1'b1;
        state_next = fsr_pkg::S_ABS;
      end
      fsr_pkg::S_ABS: begin
        cmd.abs_load = 1'b1;
        state_next   = fsr_pkg::S_GCD;
      end
      fsr_pkg::S_GCD: begin
        if (status.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = fsr_pkg::S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      fsr_pkg::S_DIV: begin
        if (status.div_done) begin
          state_next = fsr_pkg::S_UPDATE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      fsr_pkg::S_UPDATE: begin
        cmd.acc_update = 1'b1;
        state_next     = status.last ? fsr_pkg::S_EMIT : fsr_pkg::S_IDLE;
      end
      fsr_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fsr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/fsr_datapath.sv]
// Datapath: accumulator, shared multiplier, binary gcd and paired exact dividers
module fsr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fsr_pkg::cmd_t                   cmd,
  output fsr_pkg::status_t                status,
  input  logic signed [fsr_pkg::IN_W-1:0] numerator,
  input  logic        [fsr_pkg::IN_W-1:0] denominator,
  input  logic                            last,
  fsr_out_if.source                       result
);

  localparam int IW = fsr_pkg::IN_W;
  localparam int NW = fsr_pkg::NUM_W;
  localparam int DW = fsr_pkg::DEN_W;
  localparam int PW = fsr_pkg::PROD_W;
  localparam int MW = fsr_pkg::MAG_W;

  logic [IW-1:0] n_r;
  logic [IW-1:0] d_r;
  logic          last_r;

  logic [NW-1:0] acc_num;
  logic [DW-1:0] acc_den;
  logic          in_group;
  logic          ovf_seen;

  logic signed [NW:0]   mul_a;
  logic signed [IW:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] x;
  logic        [PW-1:0] xabs;

  logic [MW-1:0]               mag_r;
  logic [MW-1:0]               y_r;
  logic                        neg_r;
  logic [MW-1:0]               u;
  logic [MW-1:0]               v;
  logic [fsr_pkg::SHIFT_W-1:0] k;
  logic [MW-1:0]               g;

  logic [MW-1:0]             rem_m;
  logic [MW-1:0]             q_m;
  logic [MW-1:0]             rem_y;
  logic [MW-1:0]             q_y;
  logic [fsr_pkg::CNT_W-1:0] cnt;
  logic [MW+1:0]             trial_m;
  logic [MW+1:0]             trial_y;

  logic [MW-1:0] qm;
  logic [MW-1:0] qy;
  logic [NW-1:0] num_next;
  logic [DW-1:0] den_next;
  logic          sat_next;

  logic          out_valid;
  logic [NW-1:0] out_num;
  logic [DW-1:0] out_den;
  logic          out_ovf;

  // shared multiplier operand select
  always_comb begin
    mul_a = {acc_num[NW-1], acc_num};
    mul_b = {1'b0, d_r};
    if (cmd.mul_bn || cmd.mul_bd) begin
      mul_a = {2'b00, acc_den};
    end
    if (cmd.mul_bn) begin
      mul_b = {n_r[IW-1], n_r};
    end
  end

  always_comb begin
    xabs = x[PW-1] ? ($unsigned(~x) + 1'b1) : $unsigned(x);
  end

  always_comb begin
    trial_m = {1'b0, rem_m, q_m[MW-1]} - {2'b00, g};
    trial_y = {1'b0, rem_y, q_y[MW-1]} - {2'b00, g};
  end

  // saturate the reduced sum into the accumulator range
  always_comb begin
    qm       = (g == '0) ? mag_r : q_m;
    qy       = (g == '0) ? y_r : q_y;
    sat_next = 1'b0;
    if (neg_r) begin
      if (qm > fsr_pkg::NUM_NEG_MAX) begin
        num_next = {1'b1, {(NW-1){1'b0}}};
        sat_next = 1'b1;
      end else begin
        num_next = ~qm[NW-1:0] + 1'b1;
      end
    end else begin
      if (qm > fsr_pkg::NUM_POS_MAX) begin
        num_next = {1'b0, {(NW-1){1'b1}}};
        sat_next = 1'b1;
      end else begin
        num_next = qm[NW-1:0];
      end
    end
    if (qy > fsr_pkg::DEN_MAX) begin
      den_next = '1;
      sat_next = 1'b1;
    end else begin
      den_next = qy[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r    <= numerator;
      d_r    <= denominator;
      last_r <= last;
    end
    if (cmd.mul_ad || cmd.mul_bn || cmd.mul_bd) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_bn) begin
      x <= prod;
    end
    if (cmd.mul_bd) begin
      x <= x + prod;
    end
    if (cmd.abs_load) begin
      neg_r <= x[PW-1];
      mag_r <= xabs[MW-1:0];
      u     <= xabs[MW-1:0];
      y_r   <= prod[MW-1:0];
      v     <= prod[MW-1:0];
      k     <= '0;
    end
    if (cmd.gcd_step) begin
      priority if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end
    if (cmd.div_init) begin
      g     <= (u | v) << k;
      q_m   <= mag_r;
      q_y   <= y_r;
      rem_m <= '0;
      rem_y <= '0;
      cnt   <= '0;
    end
    if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (!trial_m[MW+1]) begin
        rem_m <= trial_m[MW-1:0];
        q_m   <= {q_m[MW-2:0], 1'b1};
      end else begin
        rem_m <= {rem_m[MW-2:0], q_m[MW-1]};
        q_m   <= {q_m[MW-2:0], 1'b0};
      end
      if (!trial_y[MW+1]) begin
        rem_y <= trial_y[MW-1:0];
        q_y   <= {q_y[MW-2:0], 1'b1};
      end else begin
        rem_y <= {rem_y[MW-2:0], q_y[MW-1]};
        q_y   <= {q_y[MW-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_num <= acc_num;
      out_den <= acc_den;
      out_ovf <= ovf_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num   <= '0;
      acc_den   <= {{(DW-1){1'b0}}, 1'b1};
      in_group  <= 1'b0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_first) begin
        acc_num  <= {{(NW-IW){n_r[IW-1]}}, n_r};
        acc_den  <= {{(DW-IW){1'b0}}, d_r};
        ovf_seen <= 1'b0;
        in_group <= 1'b1;
      end
      if (cmd.acc_update) begin
        acc_num <= num_next;
        acc_den <= den_next;
        if (sat_next) begin
          ovf_seen <= 1'b1;
        end
      end
      if (cmd.emit) begin
        in_group  <= 1'b0;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.in_group = in_group;
  assign status.last     = last_r;
  assign status.gcd_done = (u == '0) || (v == '0);
  assign status.div_done = (cnt == fsr_pkg::CNT_W'(MW));
  assign status.out_free = !out_valid || result.ready;

  assign result.valid           = out_valid;
  assign result.sum_numerator   = out_num;
  assign result.sum_denominator = out_den;
  assign result.overflow        = out_ovf;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the fraction sum reducer: random fraction groups against a predictor
`timescale 1ns / 1ps

module testbench;

  localparam int IW = fsr_pkg::IN_W;
  localparam int NW = fsr_pkg::NUM_W;
  localparam int DW = fsr_pkg::DEN_W;

  typedef struct {
    logic signed [IW-1:0] num;
    logic        [IW-1:0] den;
    logic                 last;
  } fraction_t;

  typedef struct {
    logic signed [NW-1:0] num;
    logic        [DW-1:0] den;
    logic                 ovf;
  } sum_t;

  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_HOLD    = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fsr_in_if  fraction();
  fsr_out_if result();

  fraction_sum_reducer uut (
    .clk(clk),
    .rst(rst),
    .fraction(fraction),
    .result(result)
  );

  always #5 clk = ~clk;

  fraction_t fraction_queue[$];
  sum_t      sum_queue[$];
  fraction_t on_wire;

  logic signed [NW-1:0] acc_num = '0;
  logic        [31:0]   acc_den = 32'd1;
  logic                 grp_open = 1'b0;
  logic                 grp_ovf = 1'b0;

  int errors = 0;
  int fractions_sent = 0;
  int sums_expected = 0;
  int sums_seen = 0;
  int sums_saturated = 0;

  task automatic fold_fraction(input fraction_t f);
    longint          n;
    longint          a;
    longint          x;
    longint unsigned b;
    longint unsigned dd;
    longint unsigned y;
    longint unsigned mag;
    longint unsigned gx;
    longint unsigned gy;
    longint unsigned t;
    bit              neg;
    sum_t            s;
    n  = 64'(f.num);
    dd = 64'(f.den);
    if (!grp_open) begin
      acc_num  = NW'(f.num);
      acc_den  = 32'(f.den);
      grp_ovf  = 1'b0;
      grp_open = 1'b1;
    end else begin
      a   = 64'(acc_num);
      b   = 64'(acc_den);
      x   = a * longint'(dd) + longint'(b) * n;
      y   = b * dd;
      neg = x < 0;
      mag = neg ? $unsigned(-x) : $unsigned(x);
      gx  = mag;
      gy  = y;
      while (gy != 0) begin
        t  = gx % gy;
        gx = gy;
        gy = t;
      end
      if (gx != 0) begin
        mag = mag / gx;
        y   = y / gx;
      end
      if (neg) begin
        if (mag > 64'(fsr_pkg::NUM_NEG_MAX)) begin
          mag     = 64'(fsr_pkg::NUM_NEG_MAX);
          grp_ovf = 1'b1;
        end
        acc_num = NW'(-longint'(mag));
      end else begin
        if (mag > 64'(fsr_pkg::NUM_POS_MAX)) begin
          mag     = 64'(fsr_pkg::NUM_POS_MAX);
          grp_ovf = 1'b1;
        end
        acc_num = NW'(mag);
      end
      if (y > 64'(fsr_pkg::DEN_MAX)) begin
        y       = 64'(fsr_pkg::DEN_MAX);
        grp_ovf = 1'b1;
      end
      acc_den = 32'(y);
    end
    if (f.last) begin
      s.num = acc_num;
      s.den = acc_den[DW-1:0];
      s.ovf = grp_ovf;
      sum_queue.push_back(s);
      sums_expected++;
      if (grp_ovf)
        sums_saturated++;
      grp_open = 1'b0;
    end
  endtask

  task automatic queue_fraction(input int n, input int d, input bit l);
    fraction_t f;
    f.num  = IW'(n);
    f.den  = IW'(d);
    f.last = l;
    fraction_queue.push_back(f);
  endtask

  // sender: bursts of requests separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      fraction.valid <= 1'b0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else if (!fraction.valid || fraction.ready) begin
      if (fraction.valid) begin
        fold_fraction(on_wire);
        fractions_sent++;
      end
      if (gap_left != 0) begin
        gap_left       <= gap_left - 1;
        fraction.valid <= 1'b0;
      end else if (fraction_queue.size() != 0) begin
        on_wire               = fraction_queue.pop_front();
        fraction.valid       <= 1'b1;
        fraction.numerator   <= on_wire.num;
        fraction.denominator <= on_wire.den;
        fraction.last        <= on_wire.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 4) == 0)
            gap_left <= 0;
          else if ($urandom_range(0, 2) == 0)
            gap_left <= $urandom_range(20, 180);
          else
            gap_left <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        fraction.valid <= 1'b0;
      end
    end
  end

  // receiver: check accepted sums, stall in changing patterns, hold off once for long
  int  recv_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;

  always @(posedge clk) begin : receiver
    sum_t want;
    if (rst) begin
      result.ready <= 1'b0;
      recv_mode    <= 0;
      mode_left    <= 0;
      hold_left    <= 0;
    end else begin
      if (result.valid && result.ready) begin
        sums_seen++;
        if (sum_queue.size() == 0) begin
          $error("unexpected sum: sum_numerator %0d sum_denominator %0d overflow %0b",
                 result.sum_numerator, result.sum_denominator, result.overflow);
          errors++;
        end else begin
          want = sum_queue.pop_front();
          if (result.sum_numerator !== want.num) begin
            $error("sum_numerator: expected %0d actual %0d", want.num, result.sum_numerator);
            errors++;
          end
          if (result.sum_denominator !== want.den) begin
            $error("sum_denominator: expected %0d actual %0d",
                   want.den, result.sum_denominator);
            errors++;
          end
          if (result.overflow !== want.ovf) begin
            $error("overflow: expected %0b actual %0b", want.ovf, result.overflow);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        result.ready <= 1'b0;
      end else if (!held_once && sums_seen >= 40) begin
        held_once    <= 1'b1;
        hold_left    <= LONG_HOLD;
        result.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          recv_mode <= $urandom_range(0, 2);
          mode_left <= $urandom_range(64, 512);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (recv_mode)
          0: result.ready <= 1'b1;
          1: result.ready <= 1'($urandom_range(0, 1));
          default: result.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    int glen;
    int style;
    fraction.valid       = 1'b0;
    fraction.numerator   = '0;
    fraction.denominator = 16'd1;
    fraction.last        = 1'b0;
    result.ready         = 1'b0;

    queue_fraction(32767, 65535, 1);
    queue_fraction(-32768, 1, 1);
    queue_fraction(0, 65535, 1);
    queue_fraction(6, 4, 1);
    queue_fraction(1, 2, 0);
    queue_fraction(1, 2, 1);
    queue_fraction(3, 4, 0);
    queue_fraction(-3, 4, 1);
    queue_fraction(-1, 3, 0);
    queue_fraction(-1, 6, 1);
    queue_fraction(1, 65521, 0);
    queue_fraction(1, 65519, 1);
    queue_fraction(1, 1, 1);
    queue_fraction(32767, 65521, 0);
    queue_fraction(32767, 65519, 1);
    queue_fraction(-32768, 65521, 0);
    queue_fraction(-32768, 65519, 0);
    queue_fraction(5, 7, 1);
    queue_fraction(-32768, 65535, 0);
    queue_fraction(-32768, 65534, 1);
    queue_fraction(6, 4, 0);
    queue_fraction(10, 8, 0);
    queue_fraction(-1, 65535, 1);

    while (fraction_queue.size() < RANDOM_ITEMS) begin
      glen  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      style = $urandom_range(0, 3);
      for (int k = 0; k < glen; k++) begin
        case (style)
          0: queue_fraction($urandom(), $urandom_range(1, 65535), k == glen - 1);
          1: queue_fraction($urandom_range(0, 64) - 32, $urandom_range(1, 12), k == glen - 1);
          2: queue_fraction($urandom(), 1 << $urandom_range(0, 15), k == glen - 1);
          default: queue_fraction($urandom_range(0, 2000) - 1000, $urandom_range(1, 300),
                                  k == glen - 1);
        endcase
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (fraction_queue.size() != 0 || fraction.valid || sum_queue.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d fractions, checked %0d reduced sums (%0d expected, %0d saturated).",
             fractions_sent, sums_seen, sums_expected, sums_saturated);
    if (errors == 0)
      $display("PASS fraction_sum_reducer");
    else
      $display("FAIL fraction_sum_reducer");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL fraction_sum_reducer");
    $finish;
  end

endmodule
